### rtl/kcrd_pkg.sv
// Package for the key chip register divider: shared constants and the
// request/response structs between the top level and the divider unit.
// No dependencies.
package kcrd_pkg;

    localparam int OFFSET_W  = 13;
    localparam int BYTE_W    = 8;
    localparam int HALF_W    = 16;
    localparam int WIDE_W    = 32;
    localparam int LOW_COUNT = 5;
    localparam int LOW_IDX_W = 3;
    localparam int CFG_IDX_W = 1;

    // Number of restoring division steps and the width of their counter.
    localparam int DIV_STEPS = WIDE_W;
    localparam int DIV_CNT_W = 5;

    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    // Offsets of the low registers with side effects.
    localparam logic [LOW_IDX_W-1:0] OFF_DIVISOR = 3'd1;
    localparam logic [LOW_IDX_W-1:0] OFF_DIVIDE  = 3'd3;
    localparam logic [LOW_IDX_W-1:0] OFF_ID      = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_CHIP_ID  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ID_QUERY = 1'b1;

    localparam logic [BYTE_W-1:0] WIDE_KEY      = 8'h0c;
    localparam logic [HALF_W-1:0] DIV_ZERO_QUOT = 16'hffff;

    typedef struct packed {
        logic              start;
        logic [WIDE_W-1:0] dividend;
        logic [HALF_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [HALF_W-1:0] quotient;
        logic [HALF_W-1:0] remainder;
    } div_rsp_t;

endpackage

### rtl/kcrd_if.sv
// Channel interfaces of the key chip register divider: bus access in,
// read data out. Depends on kcrd_pkg for the field widths.
interface kcrd_access_if
    import kcrd_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                func;
    logic [OFFSET_W-1:0] offset;
    logic [BYTE_W-1:0]   data;

    modport source (output valid, output func, output offset, output data, input ready);
    modport sink   (input valid, input func, input offset, input data, output ready);
endinterface

interface kcrd_result_if
    import kcrd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] read_data;

    modport source (output valid, output read_data, input ready);
    modport sink   (input valid, input read_data, output ready);
endinterface

### rtl/kcrd_divider.sv
// Bit-serial restoring 32/16 divider, one quotient bit per cycle.
// Depends on kcrd_pkg for widths and the request/response structs.
module kcrd_divider
    import kcrd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [HALF_W-1:0]    rem_reg;
    logic [WIDE_W-1:0]    quo_reg;
    logic [HALF_W-1:0]    div_reg;

    logic [HALF_W:0]      shifted;
    logic [HALF_W+1:0]    diff;
    logic                 fits;

    // Shift the next dividend bit into the partial remainder and try to subtract.
    assign shifted = {rem_reg, quo_reg[WIDE_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, div_reg};
    assign fits    = ~diff[HALF_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            // Done pulses for one cycle after the last step.
            done_reg <= busy_reg && !req.start && (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            div_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[HALF_W-1:0] : shifted[HALF_W-1:0];
            quo_reg <= {quo_reg[WIDE_W-2:0], fits};
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg[HALF_W-1:0];
    assign rsp.remainder = rem_reg;

endmodule

### rtl/key_chip_register_divider_top.sv
// Top level of the key chip register divider: byte register window with
// a bit-serial divider. Depends on kcrd_pkg, kcrd_if and kcrd_divider.
//
// Usage: bus accesses arrive as transactions on the access channel (func,
// offset, data). A write produces no result; a read produces exactly one
// transaction on the result channel carrying the stored byte. Reads beyond
// the window return zero and writes beyond it are dropped.
// A read of bytes 0..4 or beyond the window is presented in the cycle after
// acceptance; a read of the window memory passes first through the
// registered memory read. A write leaves the block idle, except a write to
// offset 3 with a nonzero divisor: the accepting cycle starts the restoring
// divider, which runs its 32 steps before the quotient and remainder are
// written back to bytes 0..3. Access is not ready while it runs.
// The result channel has an output register, so a new access is taken while
// a result waits, as long as the register is free or being emptied that
// cycle. A stalled receiver keeps access not ready and holds a memory read in S_RDATA.
// Reset clears the low registers, divisor, last dividend, wide mode and the
// configuration; the window memory is not cleared and needs no sweep.
module key_chip_register_divider_top
    import kcrd_pkg::*;
#(
    parameter int WINDOW_BYTES = 8192
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    kcrd_access_if.sink          access,
    kcrd_result_if.source        result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data
);

    localparam int               ADDR_W    = $clog2(WINDOW_BYTES);
    localparam logic [OFFSET_W:0] WIN_LIMIT = (OFFSET_W+1)'(WINDOW_BYTES);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RDATA = 2'd1;
    localparam logic [1:0] S_DIV   = 2'd2;

    logic [1:0]        state_reg;
    logic [BYTE_W-1:0] low_reg [LOW_COUNT];
    logic [HALF_W-1:0] divisor_reg;
    logic [HALF_W-1:0] last_dividend_reg;
    logic              wide_reg;
    logic [BYTE_W-1:0] chip_id_reg;
    logic [BYTE_W-1:0] query_reg;
    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_data_reg;

    logic [BYTE_W-1:0] window_mem [WINDOW_BYTES];
    logic [BYTE_W-1:0] mem_rd_reg;

    logic                 out_free;
    logic                 out_load;
    logic [BYTE_W-1:0]    out_data_next;
    logic                 accept;
    logic                 in_window;
    logic                 is_low;
    logic                 mem_we;
    logic                 mem_re;
    logic [ADDR_W-1:0]    mem_addr;
    logic [LOW_IDX_W-1:0] low_idx;
    logic [BYTE_W-1:0]    low_wdata;
    logic [HALF_W-1:0]    fresh;
    logic [BYTE_W-1:0]    low_rdata;
    div_req_t             div_req;
    div_rsp_t             div_rsp;

    // The output register is free when empty or when its content leaves now.
    assign out_free     = ~out_valid_reg | result.ready;
    assign access.ready = (state_reg == S_IDLE) & out_free;
    assign accept       = access.valid & access.ready;

    assign in_window = {1'b0, access.offset} < WIN_LIMIT;
    assign is_low    = access.offset < OFFSET_W'(LOW_COUNT);
    assign low_idx   = access.offset[LOW_IDX_W-1:0];
    assign mem_addr  = access.offset[ADDR_W-1:0];
    assign mem_we    = accept & (access.func == FUNC_WRITE) & in_window & ~is_low;
    assign mem_re    = accept & (access.func == FUNC_READ) & in_window & ~is_low;

    // A write of the query value to the identifier byte is replaced by the chip ID.
    assign low_wdata = ((low_idx == OFF_ID) && (access.data == query_reg)) ?
                       chip_id_reg : access.data;

    // Reads outside the window answer zero.
    assign low_rdata = (in_window && is_low) ? low_reg[low_idx] : '0;

    // The output register loads either a direct read answer at acceptance or
    // the registered memory byte once the memory read has completed.
    assign out_load      = ((state_reg == S_RDATA) & out_free) |
                           (accept & (access.func == FUNC_READ) & ~(in_window & ~is_low));
    assign out_data_next = (state_reg == S_RDATA) ? mem_rd_reg : low_rdata;

    assign fresh            = {low_reg[2], access.data};
    assign div_req.start    = accept & (access.func == FUNC_WRITE) & is_low &
                              (low_idx == OFF_DIVIDE) & (divisor_reg != '0);
    assign div_req.dividend = wide_reg ? {last_dividend_reg, fresh} : {{HALF_W{1'b0}}, fresh};
    assign div_req.divisor  = divisor_reg;

    kcrd_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            window_mem[mem_addr] <= access.data;
        end
        if (mem_re)
        begin
            mem_rd_reg <= window_mem[mem_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            for (int i = 0; i < LOW_COUNT; i++)
            begin
                low_reg[i] <= '0;
            end
            divisor_reg       <= '0;
            last_dividend_reg <= '0;
            wide_reg          <= 1'b0;
            chip_id_reg       <= '0;
            query_reg         <= '0;
            out_valid_reg     <= 1'b0;
            out_data_reg      <= '0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= out_data_next;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_CHIP_ID:  chip_id_reg <= cfg_data;
                    CFG_ID_QUERY: query_reg   <= cfg_data;
                    default:      ;
                endcase
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (access.func == FUNC_READ)
                        begin
                            if (in_window && !is_low)
                            begin
                                state_reg <= S_RDATA;
                            end
                        end
                        else if (in_window && is_low)
                        begin
                            unique case (low_idx)
                                OFF_DIVISOR:
                                begin
                                    low_reg[OFF_DIVISOR] <= low_wdata;
                                    divisor_reg <= {low_reg[0], access.data};
                                end
                                OFF_DIVIDE:
                                begin
                                    last_dividend_reg <= fresh;
                                    if (divisor_reg == '0)
                                    begin
                                        low_reg[0] <= '0;
                                        low_reg[1] <= '0;
                                        low_reg[2] <= DIV_ZERO_QUOT[HALF_W-1:BYTE_W];
                                        low_reg[3] <= DIV_ZERO_QUOT[BYTE_W-1:0];
                                    end
                                    else
                                    begin
                                        low_reg[OFF_DIVIDE] <= low_wdata;
                                        state_reg <= S_DIV;
                                    end
                                end
                                OFF_ID:
                                begin
                                    low_reg[OFF_ID] <= low_wdata;
                                    wide_reg <= (low_wdata == WIDE_KEY);
                                end
                                default:
                                begin
                                    low_reg[low_idx] <= low_wdata;
                                end
                            endcase
                        end
                    end
                end
                S_RDATA:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        low_reg[0] <= div_rsp.remainder[HALF_W-1:BYTE_W];
                        low_reg[1] <= div_rsp.remainder[BYTE_W-1:0];
                        low_reg[2] <= div_rsp.quotient[HALF_W-1:BYTE_W];
                        low_reg[3] <= div_rsp.quotient[BYTE_W-1:0];
                        state_reg  <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.read_data = out_data_reg;

endmodule
